// ===== design/gewg_pkg.sv =====
// Shared package of the grid edge weight generator: widths, payload structs,
// controller states and the command/status bundle between control and datapath.
// No dependencies.
`default_nettype none

package gewg_pkg;

  // Defaults for the top-level size parameters
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  // Configuration port
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 11'd1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_idx_e;

  // Payload widths
  localparam int COMP_W = 8;
  localparam int IDX_W  = 20;
  localparam int WT_W   = 13;

  // Distance arithmetic: squares, their sum, Q18.8 radicand and root remainder
  localparam int SQ_W       = 2 * COMP_W;
  localparam int SUM_W      = SQ_W + 2;
  localparam int FRAC_SH    = 8;
  localparam int RAD_W      = 2 * WT_W;
  localparam int REM_W      = WT_W + 3;
  localparam int ROOT_STEPS = WT_W;
  localparam int STEP_W     = $clog2(ROOT_STEPS);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(ROOT_STEPS - 1);

  typedef struct packed {
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [IDX_W-1:0] from_index;
    logic [IDX_W-1:0] to_index;
    logic [WT_W-1:0]  weight;
    logic             vertical;
    logic             last_of_pixel;
  } edge_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SUM,
    ST_ROOT,
    ST_EMIT,
    ST_STORE
  } state_e;

  typedef struct packed {
    logic accept;     // latch pixel, read line store
    logic square;     // register component squares and own index
    logic sel_vert;   // neighbor is the pixel above
    logic sum;        // load square root unit
    logic root_step;  // one root digit
    logic emit;       // load result register
    logic last;       // last edge of this pixel
    logic store;      // write line store, left pixel, advance counters
  } dp_cmd_t;

  typedef struct packed {
    logic col_nz;
    logic row_nz;
  } dp_status_t;

  function automatic logic [COMP_W-1:0] abs_diff(input logic [COMP_W-1:0] a,
                                                 input logic [COMP_W-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

`default_nettype wire

// ===== design/gewg_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module gewg_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== design/gewg_ctrl.sv =====
// Controller of the grid edge weight generator: sequences accept, distance,
// result and store steps per pixel. Depends on gewg_pkg.
`default_nettype none

module gewg_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  input  wire gewg_pkg::dp_status_t  status_i,
  output gewg_pkg::dp_cmd_t          cmd_o
);
  import gewg_pkg::*;

  state_e             state_q, state_d;
  logic               vert_q, vert_d;          // current edge is the vertical one
  logic               need_v_q, need_v_d;      // pixel has an edge from above
  logic               out_full_q, out_full_d;  // result register holds a beat
  logic               out_free;                // result register can take a beat
  logic [STEP_W-1:0]  step_q, step_d;

  assign out_free = !out_full_q || !out_stall_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (status_i.col_nz || status_i.row_nz) ? ST_SQUARE : ST_STORE;
        end
      end
      ST_SQUARE: state_d = ST_SUM;
      ST_SUM:    state_d = ST_ROOT;
      ST_ROOT: begin
        if (step_q == STEP_LAST) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = (!vert_q && need_v_q) ? ST_SQUARE : ST_STORE;
        end
      end
      ST_STORE:  state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Edge bookkeeping, result register occupancy and root step count
  always_comb begin
    vert_d     = vert_q;
    need_v_d   = need_v_q;
    out_full_d = out_full_q;
    step_d     = step_q;
    if (state_q == ST_IDLE && in_valid_i) begin
      vert_d   = !status_i.col_nz;
      need_v_d = status_i.row_nz;
    end
    if (state_q == ST_EMIT && out_free) begin
      vert_d     = 1'b1;
      out_full_d = 1'b1;
    end else if (!out_stall_i) begin
      out_full_d = 1'b0;
    end
    if (state_q == ST_SUM) begin
      step_d = '0;
    end else if (state_q == ST_ROOT) begin
      step_d = step_q + STEP_W'(1);
    end
  end

  // Outputs
  always_comb begin
    cmd_o          = '0;
    cmd_o.sel_vert = vert_q;
    cmd_o.last     = vert_q || !need_v_q;
    in_stall_o     = 1'b1;
    out_valid_o    = out_full_q;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      ST_SQUARE: cmd_o.square    = 1'b1;
      ST_SUM:    cmd_o.sum       = 1'b1;
      ST_ROOT:   cmd_o.root_step = 1'b1;
      ST_EMIT:   cmd_o.emit      = out_free;
      ST_STORE:  cmd_o.store     = 1'b1;
      default:   cmd_o.accept    = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      vert_q     <= 1'b0;
      need_v_q   <= 1'b0;
      out_full_q <= 1'b0;
      step_q     <= '0;
    end else begin
      state_q    <= state_d;
      vert_q     <= vert_d;
      need_v_q   <= need_v_d;
      out_full_q <= out_full_d;
      step_q     <= step_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/gewg_dp.sv =====
// Datapath of the grid edge weight generator: size registers, counters, line
// store, squares, digit-serial square root, result register.
// Depends on gewg_pkg and gewg_ram.
`default_nettype none

module gewg_dp #(
  parameter int MAX_WIDTH  = gewg_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = gewg_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [gewg_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [gewg_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  wire gewg_pkg::pixel_t               in_data_i,
  input  wire gewg_pkg::dp_cmd_t              cmd_i,
  output gewg_pkg::dp_status_t                status_o,
  output gewg_pkg::edge_t                     out_data_o
);
  import gewg_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int WSZ_W = $clog2(MAX_WIDTH + 1);
  localparam int HSZ_W = $clog2(MAX_HEIGHT + 1);
  localparam int PIX_W = $bits(pixel_t);

  logic [CFG_W-1:0] width_q, height_q;
  logic [WSZ_W-1:0] eff_w;
  logic [HSZ_W-1:0] eff_h;
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;

  pixel_t           cur_q, left_q, nb;
  logic [PIX_W-1:0] above_raw;
  pixel_t           above;

  logic [SQ_W-1:0]  sq_r_q, sq_g_q, sq_b_q;
  logic [COMP_W-1:0] d_r, d_g, d_b;
  logic [IDX_W-1:0] here_q;
  logic [SUM_W-1:0] sum;

  logic [RAD_W-1:0] rad_q;
  logic [REM_W-1:0] rem_q, rem_sh, trial;
  logic [WT_W-1:0]  root_q;
  edge_t            out_q;

  // Effective sizes: zero reads as one, above the maximum reads as the maximum
  always_comb begin
    if (width_q == '0) begin
      eff_w = WSZ_W'(1);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      eff_w = WSZ_W'(MAX_WIDTH);
    end else begin
      eff_w = WSZ_W'(width_q);
    end
    if (height_q == '0) begin
      eff_h = HSZ_W'(1);
    end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
      eff_h = HSZ_W'(MAX_HEIGHT);
    end else begin
      eff_h = HSZ_W'(height_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_SIZE_RESET;
      height_q <= CFG_SIZE_RESET;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_IMAGE_WIDTH:  width_q  <= cfg_wdata_i;
        REG_IMAGE_HEIGHT: height_q <= cfg_wdata_i;
        default:          width_q  <= width_q;
      endcase
    end
  end

  // Raster counters
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (32'(col_q) + 32'd1 >= 32'(eff_w)) begin
      col_d = '0;
      row_d = (32'(row_q) + 32'd1 >= 32'(eff_h)) ? '0 : row_q + ROW_W'(1);
    end else begin
      col_d = col_q + COL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.store) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign status_o.col_nz = (col_q != '0);
  assign status_o.row_nz = (row_q != '0);

  // Line store: read at accept, written back at store
  gewg_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (cmd_i.store),
    .waddr_i (col_q),
    .wdata_i (cur_q),
    .re_i    (cmd_i.accept),
    .raddr_i (col_q),
    .rdata_o (above_raw)
  );

  assign above = pixel_t'(above_raw);
  assign nb    = cmd_i.sel_vert ? above : left_q;

  assign d_r = abs_diff(nb.red,   cur_q.red);
  assign d_g = abs_diff(nb.green, cur_q.green);
  assign d_b = abs_diff(nb.blue,  cur_q.blue);

  assign sum = SUM_W'(sq_r_q) + SUM_W'(sq_g_q) + SUM_W'(sq_b_q);

  // Radix-2 root digit: bring down two radicand bits, try 4*root+1
  assign rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cur_q <= in_data_i;
    end
    if (cmd_i.store) begin
      left_q <= cur_q;
    end
    if (cmd_i.square) begin
      sq_r_q <= SQ_W'(d_r) * SQ_W'(d_r);
      sq_g_q <= SQ_W'(d_g) * SQ_W'(d_g);
      sq_b_q <= SQ_W'(d_b) * SQ_W'(d_b);
      here_q <= IDX_W'(row_q) * IDX_W'(eff_w) + IDX_W'(col_q);
    end
    if (cmd_i.sum) begin
      rad_q  <= {sum, FRAC_SH'(0)};
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.root_step) begin
      rad_q <= {rad_q[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[WT_W-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[WT_W-2:0], 1'b0};
      end
    end
    if (cmd_i.emit) begin
      out_q.from_index    <= cmd_i.sel_vert ? here_q - IDX_W'(eff_w)
                                            : here_q - IDX_W'(1);
      out_q.to_index      <= here_q;
      out_q.weight        <= root_q;
      out_q.vertical      <= cmd_i.sel_vert;
      out_q.last_of_pixel <= cmd_i.last;
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

// ===== design/grid_edge_weight_generator.sv =====
// Top level of the grid edge weight generator: controller plus datapath.
// Depends on gewg_pkg, gewg_ctrl, gewg_dp (and gewg_ram below it).
//
//   channel | direction | handshake             | beat
//   --------+-----------+-----------------------+---------------------------------
//   in      | input     | in_valid_i/in_stall_o | one RGB pixel, raster order
//   out     | output    | out_valid_o/out_stall_i | one edge (indices, Q9.4 weight)
//   cfg     | input     | cfg_we_i              | image_width / image_height
//
// A pixel with no edge (first of a frame) goes straight from accept to store;
// otherwise each edge takes a pass through the single digit-serial square root
// unit (square, sum, root steps, emit); an edge load waits only while the result
// register still holds an unaccepted beat under out_stall_i.
// One pixel is processed at a time; in_stall_o is high from accept to store,
// and the pixel's last edge may still wait in the result register meanwhile.
// Reset: counters to zero, both sizes to 1024, result register empty; the line
// store is not cleared; in an unresized frame a slot is written before it is used.
`default_nettype none

module grid_edge_weight_generator #(
  parameter int MAX_WIDTH  = gewg_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = gewg_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [gewg_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [gewg_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire gewg_pkg::pixel_t               in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output gewg_pkg::edge_t                     out_data_o
);
  import gewg_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencer: one pixel at a time, left edge first, then the edge from above
  gewg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Counters, line store, distance arithmetic and result register
  gewg_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== design/gewg_chk.sv =====
// Port-level checker for the grid edge weight generator, bound to the top.
// Depends on gewg_pkg and grid_edge_weight_generator.
`default_nettype none

module gewg_chk (
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            in_valid_i,
  input wire logic            in_stall_o,
  input wire logic            out_valid_o,
  input wire logic            out_stall_i,
  input wire gewg_pkg::edge_t out_data_o
);
  import gewg_pkg::*;

  // A stalled edge stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output beat changed or dropped");

  // An accepted pixel always occupies the block: the input is stalled after its accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accept");

  // Only the left edge can be followed by another edge of the same pixel
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last_of_pixel |-> !out_data_o.vertical)
    else $error("vertical edge not last of its pixel");

  // Horizontal edge joins adjacent indices
  a_left_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.vertical
      |-> out_data_o.to_index == IDX_W'(out_data_o.from_index + IDX_W'(1)))
    else $error("horizontal edge indices not adjacent");

endmodule

bind grid_edge_weight_generator gewg_chk u_gewg_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

// ===== tb/grid_edge_weight_generator_tb.sv =====
// Self-checking testbench for grid_edge_weight_generator: streams RGB pixels
// and checks every emitted grid edge against an in-bench edge predictor.
// Depends on gewg_pkg and the grid_edge_weight_generator RTL only.

module grid_edge_weight_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gewg_pkg::*;

  localparam int unsigned MAX_W         = DEF_MAX_WIDTH;
  localparam int unsigned MAX_H         = DEF_MAX_HEIGHT;
  localparam int          SETTLE_CYCLES = 8;     // covers a no-edge pixel plus the store cycle
  localparam int          TAIL_CYCLES   = 64;    // quiet window after the last edge
  localparam int          RANDOM_PIXELS = 400;
  localparam int          MAX_REPORTS   = 10;
  localparam longint      TIMEOUT_NS    = 60_000_000;

  // DUT connections; every input has a known value from time zero
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  pixel_t               in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  edge_t                out_data_o;

  grid_edge_weight_generator uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Edge predictor state: mirrors the size registers, raster counters, the
  // left pixel and the line store of the row above.
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] img_width  = CFG_SIZE_RESET;
  logic [CFG_W-1:0] img_height = CFG_SIZE_RESET;
  int unsigned      col_pos    = 0;
  int unsigned      row_pos    = 0;
  pixel_t           left_px    = '0;
  pixel_t           line_above [MAX_W];

  edge_t expected_edges [$];   // predicted edges, oldest first

  // Run bookkeeping
  int  pixels_sent   = 0;
  int  edges_checked = 0;
  int  reg_writes    = 0;
  int  fault_count   = 0;
  bit  burst_mode    = 1'b0;   // when set, neither side idles
  int  stall_run     = 0;
  edge_t want_edge;

  // Register value as the block uses it: 0 acts as 1, above max acts as max
  function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v,
                                            input int unsigned lim);
    if (v == '0) return 1;
    if (32'(v) > lim) return lim;
    return 32'(v);
  endfunction

  // floor(sqrt(256 * squared RGB distance)), i.e. Q9.4 rounded down
  function automatic logic [WT_W-1:0] rgb_distance_q4(input pixel_t a, input pixel_t b);
    int unsigned dr, dg, db, radicand, root;
    dr = 32'((a.red   > b.red)   ? (a.red   - b.red)   : (b.red   - a.red));
    dg = 32'((a.green > b.green) ? (a.green - b.green) : (b.green - a.green));
    db = 32'((a.blue  > b.blue)  ? (a.blue  - b.blue)  : (b.blue  - a.blue));
    radicand = (dr * dr + dg * dg + db * db) << 8;
    root = $rtoi($sqrt(real'(radicand)));
    // trim any floating point slack so the root is exact
    while (root * root > radicand) root--;
    while ((root + 1) * (root + 1) <= radicand) root++;
    return WT_W'(root);
  endfunction

  // Predict the edges of one accepted pixel and advance the raster position
  task automatic compute_pixel_edges(input pixel_t px);
    int unsigned w, h, x, y, slot;
    edge_t e;
    w    = clamp_dim(img_width, MAX_W);
    h    = clamp_dim(img_height, MAX_H);
    x    = col_pos;
    y    = row_pos;
    slot = x % MAX_W;
    if (x > 0) begin
      e.from_index    = IDX_W'(y * w + x - 1);
      e.to_index      = IDX_W'(y * w + x);
      e.weight        = rgb_distance_q4(left_px, px);
      e.vertical      = 1'b0;
      e.last_of_pixel = (y == 0);
      expected_edges  = {expected_edges, e};
    end
    if (y > 0) begin
      e.from_index    = IDX_W'((y - 1) * w + x);
      e.to_index      = IDX_W'(y * w + x);
      e.weight        = rgb_distance_q4(line_above[slot], px);
      e.vertical      = 1'b1;
      e.last_of_pixel = 1'b1;
      expected_edges  = {expected_edges, e};
    end
    left_px          = px;
    line_above[slot] = px;
    // a counter already past a shrunk size still wraps after this pixel
    if (x + 1 >= w) begin
      col_pos = 0;
      row_pos = (y + 1 >= h) ? 0 : y + 1;
    end else begin
      col_pos = x + 1;
    end
  endtask

  // Idle length: mostly none, some short, a few long
  function automatic int random_gap();
    int unsigned r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(16, 48);
  endfunction

  function automatic logic [7:0] nudge(input logic [7:0] c);
    int v;
    v = int'(c) + int'($urandom_range(0, 6)) - 3;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  // Random pixel: full range, close to the left neighbor (fine rounding),
  // saturated components, or a plain repeat
  function automatic pixel_t random_pixel(input pixel_t near_px);
    pixel_t p;
    int unsigned mode;
    mode = $urandom_range(0, 9);
    if (mode < 5) begin
      p = pixel_t'(24'($urandom_range(0, 24'hFF_FFFF)));
    end else if (mode < 8) begin
      p.red   = nudge(near_px.red);
      p.green = nudge(near_px.green);
      p.blue  = nudge(near_px.blue);
    end else if (mode < 9) begin
      p.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      p.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      p.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    end else begin
      p = near_px;
    end
    return p;
  endfunction

  // Size register value: mostly small, sometimes 0, max or above max
  function automatic logic [CFG_W-1:0] pick_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return CFG_W'($urandom_range(1, 8));
    if (r < 80) return CFG_W'($urandom_range(9, 40));
    if (r < 86) return '0;
    if (r < 92) return CFG_W'(MAX_W);
    if (r < 96) return CFG_W'($urandom_range(MAX_W + 1, 2047));
    return CFG_W'($urandom_range(41, 200));
  endfunction

  // ---------------------------------------------------------------------------
  // Input side. Valid stays high between back-to-back beats; the beat is taken
  // at the first edge with stall low. Prediction happens at that edge.
  // ---------------------------------------------------------------------------
  task automatic send_pixel(input pixel_t px);
    int gap;
    gap = random_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= px;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    compute_pixel_edges(px);
    pixels_sent++;
  endtask

  // Drop valid and wait for every predicted edge, then let the store finish
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_edges.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Register write, only with the block idle
  task automatic write_reg(input reg_idx_e idx, input logic [CFG_W-1:0] val);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) img_width = val;
    else img_height = val;
    reg_writes++;
  endtask

  task automatic set_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stall bursts, then compare each taken beat with the
  // oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    int n;
    if (stall_run > 0) begin
      stall_run   <= stall_run - 1;
      out_stall_i <= 1'b1;
    end else if (!burst_mode && $urandom_range(0, 3) == 0) begin
      n = random_gap();
      if (n < 1) n = 1;
      stall_run   <= n - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (expected_edges.size() == 0) begin
        fault_count++;
        if (fault_count <= MAX_REPORTS)
          $display("[%0t] unexpected edge: from %0d to %0d weight %0d vert %0b last %0b",
                   $time, out_data_o.from_index, out_data_o.to_index,
                   out_data_o.weight, out_data_o.vertical, out_data_o.last_of_pixel);
      end else begin
        want_edge = expected_edges.pop_front();
        edges_checked++;
        if (out_data_o.from_index    !== want_edge.from_index ||
            out_data_o.to_index      !== want_edge.to_index ||
            out_data_o.weight        !== want_edge.weight ||
            out_data_o.vertical      !== want_edge.vertical ||
            out_data_o.last_of_pixel !== want_edge.last_of_pixel) begin
          fault_count++;
          if (fault_count <= MAX_REPORTS)
            $display({"[%0t] edge mismatch: exp from %0d to %0d weight %0d vert %0b last %0b",
                      " | got from %0d to %0d weight %0d vert %0b last %0b"},
                     $time, want_edge.from_index, want_edge.to_index, want_edge.weight,
                     want_edge.vertical, want_edge.last_of_pixel,
                     out_data_o.from_index, out_data_o.to_index, out_data_o.weight,
                     out_data_o.vertical, out_data_o.last_of_pixel);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // 3x3 frame: first pixel, left only, above only, both; black/white
  // extremes and a one-step difference
  task automatic test_small_grid();
    pixel_t grid3 [9] = '{
      '{8'h00, 8'h00, 8'h00}, '{8'hFF, 8'hFF, 8'hFF}, '{8'hFF, 8'h00, 8'h00},
      '{8'h00, 8'hFF, 8'h00}, '{8'h00, 8'h00, 8'hFF}, '{8'h01, 8'h02, 8'h03},
      '{8'hFF, 8'hFF, 8'hFF}, '{8'hFE, 8'hFF, 8'hFF}, '{8'h00, 8'h00, 8'h00}
    };
    set_size(11'd3, 11'd3);
    foreach (grid3[i]) send_pixel(grid3[i]);
  endtask

  // Zero width acts as one (vertical edges only), 0x0 acts as 1x1 (no edges
  // at all), single row (horizontal only)
  task automatic test_degenerate_sizes();
    set_size(11'd0, 11'd3);
    repeat (3) send_pixel(random_pixel(left_px));
    set_size(11'd0, 11'd0);
    repeat (3) send_pixel(random_pixel(left_px));
    set_size(11'd4, 11'd1);
    repeat (4) send_pixel(random_pixel(left_px));
  endtask

  // An above-max width clamps to a full-width row that fills every line store
  // slot; a few pixels of the next row then take their edge from above
  task automatic test_extreme_sizes();
    set_size(11'd2047, 11'd2);
    repeat (MAX_W + 16) send_pixel(random_pixel(left_px));
  endtask

  // Size changes inside a frame: shrink width past the column, shrink height
  // past the row, then grow both. Safe now that every store slot is written.
  task automatic test_mid_frame_resize();
    set_size(11'd5, 11'd3);
    repeat (7) send_pixel(random_pixel(left_px));
    write_reg(REG_IMAGE_WIDTH, 11'd2);
    repeat (2) send_pixel(random_pixel(left_px));
    write_reg(REG_IMAGE_HEIGHT, 11'd1);
    repeat (3) send_pixel(random_pixel(left_px));
    set_size(11'd9, 11'd4);
    repeat (12) send_pixel(random_pixel(left_px));
  endtask

  // Random phases: new sizes between phases (often mid-frame), mostly whole
  // frames of random pixels, some short partial runs, random burst phases
  task automatic test_random_stream();
    int unsigned sent, span, rem, w, h;
    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      if ($urandom_range(0, 3) != 0) begin
        if ($urandom_range(0, 1) == 1) write_reg(REG_IMAGE_WIDTH, pick_size());
        if ($urandom_range(0, 2) != 0) write_reg(REG_IMAGE_HEIGHT, pick_size());
      end
      burst_mode = ($urandom_range(0, 5) == 0);
      w = clamp_dim(img_width, MAX_W);
      h = clamp_dim(img_height, MAX_H);
      if (col_pos >= w || row_pos >= h) rem = $urandom_range(1, 20);
      else rem = (h - row_pos - 1) * w + (w - col_pos);
      span = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 40) : rem;
      if (span > 300) span = $urandom_range(40, 300);
      repeat (span) begin
        send_pixel(random_pixel(left_px));
        sent++;
        // occasional full pause until the pipeline is empty
        if ($urandom_range(0, 199) == 0) drain_results();
      end
    end
    burst_mode = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_small_grid();
    test_degenerate_sizes();
    test_extreme_sizes();
    test_mid_frame_resize();
    test_random_stream();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Run covered %0d pixels, %0d edges checked, %0d register writes", pixels_sent,
             edges_checked, reg_writes);
    $display("Sizes 0..2047 incl. clamping, a full-width row, mid-frame resizes");
    if (fault_count == 0 && expected_edges.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("FAILURE");
    $finish;
  end

endmodule
